// ===== hw/rtl/gfta_pkg.sv =====
// Shared types, constants and command codes of the GNSS fix time aligner.
// No dependencies; gfta_daymod, gfta_engine and the top level import this package.
package gfta_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam int TIME_W  = 30;
    localparam int TAG_W   = 16;
    localparam int SIGMA_W = 16;
    localparam int VAR_W   = 32;
    localparam int TOL_W   = 26;
    localparam int OFS_W   = 31;
    localparam int CFG_W   = 31;
    localparam int DAY_W   = 27;   // ms of day, below 86400000
    localparam int GW      = 33;   // signed ms of week plus offset
    localparam int RW      = 28;   // signed remainder of a day
    localparam int DIFF_W  = 31;   // signed time differences

    localparam logic signed [GW-1:0] MS_DAY_G  = 33'sd86400000;
    localparam logic signed [GW-1:0] MS_WEEK_G = 33'sd604800000;
    localparam logic signed [DIFF_W-1:0] MS_DAY_D  = 31'sd86400000;
    localparam logic signed [DIFF_W-1:0] MS_HALF_D = 31'sd43200000;

    typedef enum logic [1:0] {
        CMD_PUSH_QUALITY  = 2'd0,
        CMD_PUSH_MINIMUM  = 2'd1,
        CMD_PUSH_POSITION = 2'd2,
        CMD_DRAIN         = 2'd3
    } cmd_t;

    localparam logic [1:0] CFG_PAIR_TOL  = 2'd0;
    localparam logic [1:0] CFG_POS_TOL   = 2'd1;
    localparam logic [1:0] CFG_WAIT_POS  = 2'd2;
    localparam logic [1:0] CFG_UTC_OFS   = 2'd3;

    typedef struct packed {
        logic [TOL_W-1:0]        pair_tol;
        logic [TOL_W-1:0]        pos_tol;
        logic                    wait_pos;
        logic signed [OFS_W-1:0] utc_ofs;
    } cfg_t;

    typedef struct packed {
        cmd_t               command;
        logic [TIME_W-1:0]  time_ms;
        logic [TAG_W-1:0]   tag;
        logic [SIGMA_W-1:0] lon_sd;
        logic [SIGMA_W-1:0] lat_sd;
        logic [SIGMA_W-1:0] hgt_sd;
    } request_t;

    typedef struct packed {
        logic               has_fix;
        logic [TAG_W-1:0]   quality_tag;
        logic [TAG_W-1:0]   minimum_tag;
        logic               pos_valid;
        logic [TAG_W-1:0]   position_tag;
        logic [VAR_W-1:0]   var_lon;
        logic [VAR_W-1:0]   var_lat;
        logic [VAR_W-1:0]   var_height;
        logic               last;
    } fix_t;

endpackage

// ===== hw/rtl/gfta_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module gfta_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hw/rtl/gfta_daymod.sv =====
// Iterative remainder by one day (truncating, sign of the dividend kept).
// Depends on gfta_pkg; one add or subtract of a day per cycle.
module gfta_daymod import gfta_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic signed [GW-1:0] value,
    output logic                 done,
    output logic signed [RW-1:0] result
);

    logic                 busy_reg;
    logic signed [GW-1:0] v_reg;
    logic                 hi;
    logic                 lo;

    assign hi     = v_reg >= MS_DAY_G;
    assign lo     = v_reg <= -MS_DAY_G;
    assign done   = busy_reg && !hi && !lo;
    assign result = v_reg[RW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (start) begin
            busy_reg <= 1'b1;
        end else if (done) begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            v_reg <= value;
        end else if (busy_reg && hi) begin
            v_reg <= v_reg - MS_DAY_G;
        end else if (busy_reg && lo) begin
            v_reg <= v_reg + MS_DAY_G;
        end
    end

endmodule

// ===== hw/rtl/gfta_engine.sv =====
// Queue store and drain sequencer: four queue RAMs, head/count registers,
// pairing and position search. Depends on gfta_pkg, gfta_ram, gfta_daymod.
module gfta_engine import gfta_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     req_valid,
    output logic     req_ready,
    input  request_t req,
    input  cfg_t     cfg,
    input  logic     out_free,
    output logic     out_load,
    output fix_t     out_fix
);

    typedef enum logic [3:0] {
        S_IDLE, S_REPORT_MOD, S_PAIR_RD, S_PAIR_CMP, S_POS_RD, S_POS_SUM,
        S_POS_START, S_POS_MOD, S_POS_DONE, S_STORE, S_FINISH
    } state_t;

    localparam int QW = DAY_W + TAG_W;
    localparam int PW = TIME_W + TAG_W;
    localparam int SW = 3 * SIGMA_W;
    localparam logic [CNT_W-1:0] FULL = CNT_W'(QUEUE_DEPTH);

    state_t             state_reg;
    request_t           req_reg;
    logic [IDX_W-1:0]   head_reg  [3];
    logic [CNT_W-1:0]   count_reg [3];
    logic [IDX_W-1:0]   head_next [3];
    logic [CNT_W-1:0]   count_next[3];
    logic [2:0]         pop;
    logic               push_en;
    logic [1:0]         push_q;
    logic signed [GW-1:0] g_reg;
    logic               has_pos_reg;
    logic               use_pop_reg;
    fix_t               pending_reg;
    logic               pending_valid_reg;
    fix_t               new_reg;

    logic               accept;
    logic [IDX_W-1:0]   waddr;
    logic [QW-1:0]      q_rd, m_rd;
    logic [PW-1:0]      pt_rd;
    logic [SW-1:0]      ps_rd;
    logic               q_we, m_we, p_we, pair_re, pos_re;
    logic               mod_start, mod_done;
    logic signed [GW-1:0] mod_value;
    logic signed [RW-1:0] mod_result;
    logic [DAY_W-1:0]   qt, mt;
    logic signed [DIFF_W-1:0] pair_dt, pos_dt, pair_tol_s, pos_tol_s;
    logic signed [GW-1:0] g_fixed;

    function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] h);
        next_idx = (h == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : h + 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] tail_idx(input logic [IDX_W-1:0] h,
                                                  input logic [CNT_W-1:0] c);
        logic [CNT_W:0] s;
        s = {{(CNT_W + 1 - IDX_W){1'b0}}, h} + {1'b0, c};
        if (s >= (CNT_W + 1)'(QUEUE_DEPTH)) begin
            s = s - (CNT_W + 1)'(QUEUE_DEPTH);
        end
        tail_idx = s[IDX_W-1:0];
    endfunction

    // Fold a difference back into half a day either side of zero.
    function automatic logic signed [DIFF_W-1:0] wrap_day(
        input logic signed [DIFF_W-1:0] d);
        logic signed [DIFF_W-1:0] r;
        r = d;
        if (r > MS_HALF_D) begin
            r = r - MS_DAY_D;
        end
        if (r < -MS_HALF_D) begin
            r = r + MS_DAY_D;
        end
        wrap_day = r;
    endfunction

    assign req_ready = (state_reg == S_IDLE);
    assign accept    = req_valid && req_ready;

    assign push_q  = (state_reg == S_IDLE) ? req.command : req_reg.command;
    assign waddr   = tail_idx(head_reg[push_q], count_reg[push_q]);
    assign p_we    = accept && (req.command == CMD_PUSH_POSITION);
    assign q_we    = (state_reg == S_REPORT_MOD) && mod_done &&
                     (req_reg.command == CMD_PUSH_QUALITY);
    assign m_we    = (state_reg == S_REPORT_MOD) && mod_done &&
                     (req_reg.command == CMD_PUSH_MINIMUM);
    assign push_en = p_we || q_we || m_we;

    assign pair_re = (state_reg == S_PAIR_RD) && (count_reg[0] != '0) &&
                     (count_reg[1] != '0);
    assign pos_re  = (state_reg == S_POS_RD) && (count_reg[2] != '0);

    assign mod_start = (accept && (req.command == CMD_PUSH_QUALITY ||
                                   req.command == CMD_PUSH_MINIMUM)) ||
                       (state_reg == S_POS_START);
    assign g_fixed   = (g_reg < 0) ? g_reg + MS_WEEK_G : g_reg;
    assign mod_value = (state_reg == S_POS_START) ? g_fixed :
                       GW'({1'b0, req.time_ms});

    gfta_ram #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_quality_ram (
        .aclk(aclk), .we(q_we), .waddr(waddr),
        .wdata({mod_result[DAY_W-1:0], req_reg.tag}),
        .re(pair_re), .raddr(head_reg[0]), .rdata(q_rd));

    gfta_ram #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_minimum_ram (
        .aclk(aclk), .we(m_we), .waddr(waddr),
        .wdata({mod_result[DAY_W-1:0], req_reg.tag}),
        .re(pair_re), .raddr(head_reg[1]), .rdata(m_rd));

    gfta_ram #(.WIDTH(PW), .DEPTH(QUEUE_DEPTH)) u_pos_time_ram (
        .aclk(aclk), .we(p_we), .waddr(waddr),
        .wdata({req.time_ms, req.tag}),
        .re(pos_re), .raddr(head_reg[2]), .rdata(pt_rd));

    gfta_ram #(.WIDTH(SW), .DEPTH(QUEUE_DEPTH)) u_pos_sigma_ram (
        .aclk(aclk), .we(p_we), .waddr(waddr),
        .wdata({req.hgt_sd, req.lat_sd, req.lon_sd}),
        .re(pos_re), .raddr(head_reg[2]), .rdata(ps_rd));

    gfta_daymod u_daymod (
        .aclk(aclk), .aresetn(aresetn), .start(mod_start), .value(mod_value),
        .done(mod_done), .result(mod_result));

    assign qt = q_rd[QW-1:TAG_W];
    assign mt = m_rd[QW-1:TAG_W];
    assign pair_tol_s = DIFF_W'({1'b0, cfg.pair_tol});
    assign pos_tol_s  = DIFF_W'({1'b0, cfg.pos_tol});
    assign pair_dt = wrap_day(DIFF_W'($signed({1'b0, qt})) - DIFF_W'($signed({1'b0, mt})));
    assign pos_dt  = wrap_day(DIFF_W'($signed({1'b0, qt})) - DIFF_W'(mod_result));

    always_comb begin
        pop = '0;
        case (state_reg)
            S_PAIR_CMP: begin
                if (pair_dt > pair_tol_s) begin
                    pop[1] = 1'b1;
                end else if (pair_dt < -pair_tol_s) begin
                    pop[0] = 1'b1;
                end
            end
            S_POS_MOD: begin
                if (mod_done && pos_dt > pos_tol_s) begin
                    pop[2] = 1'b1;
                end
            end
            S_POS_DONE: begin
                if (has_pos_reg || !cfg.wait_pos) begin
                    pop[0] = 1'b1;
                    pop[1] = 1'b1;
                    pop[2] = use_pop_reg;
                end
            end
            default: pop = '0;
        endcase
    end

    // Advance heads on pops; a push into a full queue drops its oldest entry.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            head_next[i]  = head_reg[i];
            count_next[i] = count_reg[i];
            if (pop[i]) begin
                head_next[i]  = next_idx(head_reg[i]);
                count_next[i] = count_reg[i] - 1'b1;
            end
            if (push_en && push_q == 2'(i)) begin
                if (count_reg[i] == FULL) begin
                    head_next[i] = next_idx(head_reg[i]);
                end else begin
                    count_next[i] = count_reg[i] + 1'b1;
                end
            end
        end
    end

    always_comb begin
        out_fix  = pending_reg;
        out_load = 1'b0;
        case (state_reg)
            S_STORE: begin
                out_fix.last = 1'b0;
                out_load     = pending_valid_reg && out_free;
            end
            S_FINISH: begin
                if (!pending_valid_reg) begin
                    out_fix = '0;
                end
                out_fix.last = 1'b1;
                out_load     = out_free;
            end
            default: out_load = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= S_IDLE;
            pending_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                head_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
        end else begin
            for (int i = 0; i < 3; i++) begin
                head_reg[i]  <= head_next[i];
                count_reg[i] <= count_next[i];
            end
            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        req_reg <= req;
                        case (req.command)
                            CMD_PUSH_QUALITY:  state_reg <= S_REPORT_MOD;
                            CMD_PUSH_MINIMUM:  state_reg <= S_REPORT_MOD;
                            CMD_PUSH_POSITION: state_reg <= S_IDLE;
                            CMD_DRAIN:         state_reg <= S_PAIR_RD;
                            default:           state_reg <= S_IDLE;
                        endcase
                    end
                end
                S_REPORT_MOD: begin
                    if (mod_done) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_PAIR_RD: begin
                    state_reg <= pair_re ? S_PAIR_CMP : S_FINISH;
                end
                S_PAIR_CMP: begin
                    has_pos_reg <= 1'b0;
                    use_pop_reg <= 1'b0;
                    if (pop[0] || pop[1]) begin
                        state_reg <= S_PAIR_RD;
                    end else begin
                        state_reg <= S_POS_RD;
                    end
                end
                S_POS_RD: begin
                    state_reg <= pos_re ? S_POS_SUM : S_POS_DONE;
                end
                S_POS_SUM: begin
                    g_reg     <= GW'({1'b0, pt_rd[PW-1:TAG_W]}) + GW'(cfg.utc_ofs);
                    state_reg <= S_POS_START;
                end
                S_POS_START: begin
                    state_reg <= S_POS_MOD;
                end
                S_POS_MOD: begin
                    if (mod_done) begin
                        if (pop[2]) begin
                            state_reg <= S_POS_RD;
                        end else begin
                            has_pos_reg <= 1'b1;
                            use_pop_reg <= (pos_dt >= -pos_tol_s);
                            state_reg   <= S_POS_DONE;
                        end
                    end
                end
                S_POS_DONE: begin
                    if (!has_pos_reg && cfg.wait_pos) begin
                        state_reg <= S_FINISH;
                    end else begin
                        new_reg.has_fix      <= 1'b1;
                        new_reg.quality_tag  <= q_rd[TAG_W-1:0];
                        new_reg.minimum_tag  <= m_rd[TAG_W-1:0];
                        new_reg.pos_valid    <= has_pos_reg;
                        new_reg.last         <= 1'b0;
                        if (has_pos_reg) begin
                            new_reg.position_tag <= pt_rd[TAG_W-1:0];
                            new_reg.var_lon    <= ps_rd[SIGMA_W-1:0] * ps_rd[SIGMA_W-1:0];
                            new_reg.var_lat    <= ps_rd[2*SIGMA_W-1:SIGMA_W] *
                                                  ps_rd[2*SIGMA_W-1:SIGMA_W];
                            new_reg.var_height <= ps_rd[SW-1:2*SIGMA_W] *
                                                  ps_rd[SW-1:2*SIGMA_W];
                        end else begin
                            new_reg.position_tag <= '0;
                            new_reg.var_lon      <= '0;
                            new_reg.var_lat      <= '0;
                            new_reg.var_height   <= '0;
                        end
                        state_reg <= S_STORE;
                    end
                end
                S_STORE: begin
                    if (!pending_valid_reg || out_free) begin
                        pending_reg       <= new_reg;
                        pending_valid_reg <= 1'b1;
                        state_reg         <= S_PAIR_RD;
                    end
                end
                S_FINISH: begin
                    if (out_free) begin
                        pending_valid_reg <= 1'b0;
                        state_reg         <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg[0] <= FULL && count_reg[1] <= FULL && count_reg[2] <= FULL)
        else $error("queue count beyond depth");
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> out_free)
        else $error("result loaded into a busy output register");
    a_idle_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_IDLE |-> !pending_valid_reg)
        else $error("held fix left over after drain");
    a_last_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load && out_fix.last |=> state_reg == S_IDLE)
        else $error("drain continued after its final result");
`endif

endmodule

// ===== hw/rtl/gnss_fix_time_aligner.sv =====
// Top level of the GNSS fix time aligner: stream ports, configuration
// registers and the result register. Depends on gfta_pkg and gfta_engine.
//
// Use: requests enter on the s_ channel, one per handshake. Commands push a
// fix-quality report, a recommended-minimum report or a position into its
// 16-entry queue, or drain the queues. A push yields no result; a drain
// yields one result per emitted fix (tlast on the final one) or a single
// no-fix result with tlast set.
// A report push passes through the time-of-day reduction, one day subtracted
// per cycle in the remainder unit; a position push is stored on acceptance.
// A drain discards unmatched pair heads and inspects position heads, each
// through the week-time remainder, before each fix and the closing result;
// the shared remainder unit and the single read port of each queue RAM pace
// this. Requests are taken only while the sequencer is idle. Results pass
// through an output register, so the next request is accepted while the last
// result still waits; while a held result sees m_tready low the drain holds
// before its next output. Reset (aresetn low, synchronous) empties all queues
// and loads the register defaults: both tolerances 10 ms, wait mode off, UTC
// offset 0. Configuration is written through cfg_wr_en/cfg_index/cfg_wdata by
// the user only while the block is idle; the block does not enforce this.
module gnss_fix_time_aligner import gfta_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [95:0]      s_tdata,    // time_ms, tag, lon, lat, height sigma
    input  logic [1:0]       s_tuser,    // command
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [143:0]     m_tdata,    // quality, minimum, position tag, var lon/lat/height
    output logic [1:0]       m_tuser,    // has_fix, position flag
    output logic             m_tlast,
    input  logic             cfg_wr_en,
    input  logic [1:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_wdata
);

    cfg_t     cfg_reg;
    request_t req;
    fix_t     fix;
    logic     out_load;
    logic     out_free;
    logic     m_tvalid_reg;
    fix_t     m_fix_reg;

    // Hold the configuration registers; write one per enabled cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pair_tol   <= TOL_W'(10);
            cfg_reg.pos_tol    <= TOL_W'(10);
            cfg_reg.wait_pos   <= 1'b0;
            cfg_reg.utc_ofs    <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_PAIR_TOL: cfg_reg.pair_tol   <= cfg_wdata[TOL_W-1:0];
                CFG_POS_TOL:  cfg_reg.pos_tol    <= cfg_wdata[TOL_W-1:0];
                CFG_WAIT_POS: cfg_reg.wait_pos   <= cfg_wdata[0];
                CFG_UTC_OFS:  cfg_reg.utc_ofs    <= cfg_wdata[OFS_W-1:0];
                default:      cfg_reg.wait_pos   <= cfg_reg.wait_pos;
            endcase
        end
    end

    assign req.command      = cmd_t'(s_tuser);
    assign req.time_ms      = s_tdata[29:0];
    assign req.tag          = s_tdata[45:30];
    assign req.lon_sd       = s_tdata[61:46];
    assign req.lat_sd       = s_tdata[77:62];
    assign req.hgt_sd       = s_tdata[93:78];

    assign out_free = !m_tvalid_reg || m_tready;

    gfta_engine u_engine (
        .aclk(aclk), .aresetn(aresetn),
        .req_valid(s_tvalid), .req_ready(s_tready), .req(req),
        .cfg(cfg_reg), .out_free(out_free), .out_load(out_load), .out_fix(fix));

    // Result register: load a new fix when empty or being taken, else hold.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_fix_reg <= fix;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {m_fix_reg.var_height, m_fix_reg.var_lat, m_fix_reg.var_lon,
                       m_fix_reg.position_tag, m_fix_reg.minimum_tag,
                       m_fix_reg.quality_tag};
    assign m_tuser  = {m_fix_reg.pos_valid, m_fix_reg.has_fix};
    assign m_tlast  = m_fix_reg.last;

endmodule
